>>> hw/rtl/tleb_pkg.sv
package tleb_pkg;

  localparam int COORD_BITS = 16;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int LEN_BITS   = SQ_BITS + 2;
  localparam int N_VTX      = 4;
  localparam int N_EDGES    = 6;
  localparam int ITEM_BEATS = 8;
  localparam int BEAT_BITS  = $clog2(ITEM_BEATS);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [SQ_BITS-1:0]           sq_t;
  typedef logic [LEN_BITS-1:0]          len_t;
  typedef logic [1:0]                   vidx_t;
  typedef logic [2:0]                   edge_idx_t;
  typedef logic [BEAT_BITS-1:0]         beat_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  typedef struct packed {
    coord_t v0_x;
    coord_t v0_y;
    coord_t v0_z;
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
    coord_t v3_x;
    coord_t v3_y;
    coord_t v3_z;
  } tleb_in_t;

  typedef struct packed {
    coord_t     out_x;
    coord_t     out_y;
    coord_t     out_z;
    logic       piece;
    logic [1:0] corner;
    logic       last;
  } tleb_out_t;

  // Winner of the edge scan; found is low when every edge has zero length.
  typedef struct packed {
    logic      found;
    edge_idx_t idx;
  } pick_t;

  localparam logic [1:0] CORNER_N0  = 2'd0;
  localparam logic [1:0] CORNER_E   = 2'd1;
  localparam logic [1:0] CORNER_N1  = 2'd2;
  localparam logic [1:0] CORNER_MID = 2'd3;

  // Edges in scan order 03, 02, 01, 13, 12, 23.
  localparam vidx_t EDGE_E0 [N_EDGES] = '{2'd3, 2'd2, 2'd1, 2'd3, 2'd2, 2'd3};
  localparam vidx_t EDGE_E1 [N_EDGES] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam vidx_t EDGE_N0 [N_EDGES] = '{2'd2, 2'd3, 2'd3, 2'd2, 2'd3, 2'd1};
  localparam vidx_t EDGE_N1 [N_EDGES] = '{2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0};

endpackage

>>> hw/rtl/tetrahedron_longest_edge_bisect.sv
// The vertices are registered; each edge lane registers its squares, then its length;
// the merge registers pair winners, then the pick; the one-vertex-wide sequencer then
// loads and emits the beats. Busy, raised after each accepted start, refuses new starts.
// Eight beats per item come on consecutive cycles; the receiver cannot stall them.
// Reset (synchronous, active low) clears the valid pipeline, busy counter and sequencer.
module tetrahedron_longest_edge_bisect
  import tleb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  tleb_in_t  in_data,
  output logic      out_strobe,
  output tleb_out_t out_data
);

  localparam int PIPE_DEPTH = 5;

  vtx_t  s0_v_r [N_VTX];
  logic  [PIPE_DEPTH-1:0] vld_r, vld_nxt;
  beat_t gap_r, gap_nxt;
  logic  accept;
  len_t  len [N_EDGES];
  pick_t pick;

  assign accept = start && !busy;
  assign busy   = (gap_r != '0);

  // Hold the vertices until the sequencer has copied them; busy blocks a new start until then.
  always_ff @(posedge clk) begin
    if (accept) begin
      s0_v_r[0] <= '{x: in_data.v0_x, y: in_data.v0_y, z: in_data.v0_z};
      s0_v_r[1] <= '{x: in_data.v1_x, y: in_data.v1_y, z: in_data.v1_z};
      s0_v_r[2] <= '{x: in_data.v2_x, y: in_data.v2_y, z: in_data.v2_z};
      s0_v_r[3] <= '{x: in_data.v3_x, y: in_data.v3_y, z: in_data.v3_z};
    end
  end

  always_comb begin
    vld_nxt = {vld_r[PIPE_DEPTH-2:0], accept};
    if (accept) gap_nxt = beat_t'(ITEM_BEATS-1);
    else if (busy) gap_nxt = gap_r - beat_t'(1);
    else gap_nxt = gap_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      gap_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      gap_r <= gap_nxt;
    end
  end

  for (genvar g = 0; g < N_EDGES; g++) begin : g_lane
    tleb_lane u_lane (
      .clk   (clk),
      .vtx_a (s0_v_r[EDGE_E0[g]]),
      .vtx_b (s0_v_r[EDGE_E1[g]]),
      .len   (len[g])
    );
  end

  tleb_merge u_merge (
    .clk  (clk),
    .len  (len),
    .pick (pick)
  );

  tleb_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (vld_r[PIPE_DEPTH-1]),
    .pick   (pick),
    .vtx    (s0_v_r),
    .strobe (out_strobe),
    .data   (out_data)
  );

  a_load_between_runs: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[PIPE_DEPTH-1] |-> (!out_strobe || out_data.last))
    else $error("sequencer reloaded in the middle of a run");

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accepted start");

  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.last) |=> out_strobe)
    else $error("beat gap inside a run");

  a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.last) |=>
      (!out_strobe || (!out_data.piece && out_data.corner == CORNER_N0)))
    else $error("run did not restart at its first beat");

endmodule

>>> hw/rtl/tleb_lane.sv
module tleb_lane
  import tleb_pkg::*;
(
  input  logic clk,
  input  vtx_t vtx_a,
  input  vtx_t vtx_b,
  output len_t len
);

  logic signed [COORD_BITS:0]     dx, dy, dz;
  logic signed [2*COORD_BITS+1:0] px, py, pz;
  sq_t  sqx_r, sqy_r, sqz_r;
  len_t len_r;

  always_comb begin
    dx = {vtx_a.x[COORD_BITS-1], vtx_a.x} - {vtx_b.x[COORD_BITS-1], vtx_b.x};
    dy = {vtx_a.y[COORD_BITS-1], vtx_a.y} - {vtx_b.y[COORD_BITS-1], vtx_b.y};
    dz = {vtx_a.z[COORD_BITS-1], vtx_a.z} - {vtx_b.z[COORD_BITS-1], vtx_b.z};
    px = dx * dx;
    py = dy * dy;
    pz = dz * dz;
  end

  // A square of a difference is below 2**SQ_BITS, so the top bits drop.
  always_ff @(posedge clk) begin
    sqx_r <= px[SQ_BITS-1:0];
    sqy_r <= py[SQ_BITS-1:0];
    sqz_r <= pz[SQ_BITS-1:0];
    len_r <= LEN_BITS'(sqx_r) + LEN_BITS'(sqy_r) + LEN_BITS'(sqz_r);
  end

  assign len = len_r;

endmodule

>>> hw/rtl/tleb_merge.sv
module tleb_merge
  import tleb_pkg::*;
(
  input  logic  clk,
  input  len_t  len [N_EDGES],
  output pick_t pick
);

  len_t      a_len_r [N_EDGES/2];
  edge_idx_t a_idx_r [N_EDGES/2];
  len_t      b_len, f_len;
  edge_idx_t b_idx, f_idx;
  pick_t     pick_r;

  // Later edge wins only when strictly longer, so ties keep scan order.
  always_ff @(posedge clk) begin
    for (int j = 0; j < N_EDGES/2; j++) begin
      if (len[2*j+1] > len[2*j]) begin
        a_len_r[j] <= len[2*j+1];
        a_idx_r[j] <= edge_idx_t'(2*j+1);
      end else begin
        a_len_r[j] <= len[2*j];
        a_idx_r[j] <= edge_idx_t'(2*j);
      end
    end
  end

  always_comb begin
    if (a_len_r[1] > a_len_r[0]) begin
      b_len = a_len_r[1];
      b_idx = a_idx_r[1];
    end else begin
      b_len = a_len_r[0];
      b_idx = a_idx_r[0];
    end
    if (a_len_r[2] > b_len) begin
      f_len = a_len_r[2];
      f_idx = a_idx_r[2];
    end else begin
      f_len = b_len;
      f_idx = b_idx;
    end
  end

  always_ff @(posedge clk) begin
    pick_r.found <= (f_len != '0);
    pick_r.idx   <= f_idx;
  end

  assign pick = pick_r;

endmodule

>>> hw/rtl/tleb_seq.sv
module tleb_seq
  import tleb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  pick_t     pick,
  input  vtx_t      vtx [N_VTX],
  output logic      strobe,
  output tleb_out_t data
);

  vidx_t e0, e1, n0, n1;
  vtx_t  mid;
  logic signed [COORD_BITS:0] sx, sy, sz;

  vtx_t  n0_r, e0_r, e1_r, n1_r, mid_r;
  vtx_t  sel;
  beat_t beat_r, beat_nxt;
  logic  act_r, act_nxt;
  logic  at_last;

  always_comb begin
    if (pick.found) begin
      e0 = EDGE_E0[pick.idx];
      e1 = EDGE_E1[pick.idx];
      n0 = EDGE_N0[pick.idx];
      n1 = EDGE_N1[pick.idx];
    end else begin
      e0 = '0;
      e1 = '0;
      n0 = '0;
      n1 = '0;
    end
    sx = {vtx[e0].x[COORD_BITS-1], vtx[e0].x} + {vtx[e1].x[COORD_BITS-1], vtx[e1].x};
    sy = {vtx[e0].y[COORD_BITS-1], vtx[e0].y} + {vtx[e1].y[COORD_BITS-1], vtx[e1].y};
    sz = {vtx[e0].z[COORD_BITS-1], vtx[e0].z} + {vtx[e1].z[COORD_BITS-1], vtx[e1].z};
    mid.x = sx[COORD_BITS:1];
    mid.y = sy[COORD_BITS:1];
    mid.z = sz[COORD_BITS:1];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      n0_r  <= vtx[n0];
      e0_r  <= vtx[e0];
      e1_r  <= vtx[e1];
      n1_r  <= vtx[n1];
      mid_r <= mid;
    end
  end

  assign at_last = (beat_r == beat_t'(ITEM_BEATS-1));

  // A new load may land on the last beat of the previous run.
  always_comb begin
    act_nxt  = act_r;
    beat_nxt = beat_r;
    if (load) begin
      act_nxt  = 1'b1;
      beat_nxt = '0;
    end else if (act_r) begin
      beat_nxt = beat_r + beat_t'(1);
      if (at_last) act_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      beat_r <= '0;
    end else begin
      act_r  <= act_nxt;
      beat_r <= beat_nxt;
    end
  end

  always_comb begin
    case (beat_r[1:0])
      CORNER_N0:  sel = n0_r;
      CORNER_E:   sel = beat_r[BEAT_BITS-1] ? e1_r : e0_r;
      CORNER_N1:  sel = n1_r;
      CORNER_MID: sel = mid_r;
      default:    sel = mid_r;
    endcase
  end

  assign strobe      = act_r;
  assign data.out_x  = sel.x;
  assign data.out_y  = sel.y;
  assign data.out_z  = sel.z;
  assign data.piece  = beat_r[BEAT_BITS-1];
  assign data.corner = beat_r[1:0];
  assign data.last   = at_last;

endmodule
